// ----- sv/rgbrle_pkg.sv -----
// Package for the RGB image RLE row decoder: payload structs, codes,
// state types and constants. Depends on nothing.
`timescale 1ns / 1ps

package rgbrle_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int CFG_W = 13;

   localparam logic [6:0] COUNT_MASK = 7'h7f;
   localparam logic [7:0] LITERAL_FLAG = 8'h80;

   localparam logic [0:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [0:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OVERRUN = 2'd1;
   localparam logic [1:0] ST_COLUMN = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        row_start;
      logic [11:0] row_index;
      logic [1:0]  channel;
      logic [15:0] row_length;
   } req_type;

   typedef struct packed {
      logic [7:0]  pixel_first;
      logic [7:0]  pixel_second;
      logic [1:0]  pixel_count;
      logic [25:0] write_address;
      logic        row_done;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CODE,
      PH_LIT,
      PH_REP
   } phase_type;

   typedef enum logic [1:0] {
      C_WAIT,
      C_ROW,
      C_EVAL,
      C_REP
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic row;
      logic eval;
      logic rep;
   } cmd_type;

   typedef struct packed {
      logic req_row_start;
      logic slot_free;
      logic eval_result;
      logic eval_rep;
      logic rep_last;
   } stat_type;

endpackage

// ----- sv/rgbrle_ctrl.sv -----
// Controller state machine of the RGB image RLE row decoder.
// Depends on rgbrle_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps

module rgbrle_ctrl
   import rgbrle_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         C_WAIT: begin
            if (req_valid) begin
               state_in = stat.req_row_start ? C_ROW : C_EVAL;
            end
         end
         C_ROW: begin
            state_in = C_EVAL;
         end
         C_EVAL: begin
            if (stat.eval_rep) begin
               state_in = C_REP;
            end else if (stat.slot_free || !stat.eval_result) begin
               state_in = C_WAIT;
            end
         end
         C_REP: begin
            if (stat.slot_free && stat.rep_last) begin
               state_in = C_WAIT;
            end
         end
         default: begin
            state_in = C_WAIT;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         C_WAIT: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         C_ROW: begin
            cmd.row = 1'b1;
         end
         C_EVAL: begin
            cmd.eval = stat.slot_free || !stat.eval_result;
         end
         C_REP: begin
            cmd.rep = stat.slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- sv/rgbrle_dp.sv -----
// Datapath of the RGB image RLE row decoder: configuration, row state,
// address arithmetic and the result register. Depends on rgbrle_pkg.
`timescale 1ns / 1ps

module rgbrle_dp
   import rgbrle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  req_type          req_data,
   output rsp_type          rsp_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cmd_type          cmd,
   output stat_type         stat
);

   localparam logic [CFG_W-1:0] MaxWidth = CFG_W'(MAX_WIDTH);

   logic [CFG_W-1:0] width_ff, height_ff;
   req_type          item_ff;
   phase_type        phase_ff, phase_in;
   logic [6:0]       run_ff, run_in;
   logic [6:0]       rep_left_ff, rep_left_in;
   logic [15:0]      bytes_ff, bytes_in;
   logic [15:0]      budget_ff, budget_in;
   logic [25:0]      addr_ff, addr_in;
   logic [12:0]      column_ff, column_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0] eff_width;
   logic [23:0]      row_product;
   logic             overrun;
   logic [6:0]       code_count;
   logic [12:0]      column_next;
   logic             load;

   always_comb begin
      eff_width = width_ff;
      if (width_ff == '0) begin
         eff_width = CFG_W'(1);
      end else if (width_ff > MaxWidth) begin
         eff_width = MaxWidth;
      end
   end

   assign row_product = 24'(item_ff.row_index) * 24'(eff_width);
   assign overrun = bytes_ff >= budget_ff;
   assign code_count = item_ff.data_byte[6:0] & COUNT_MASK;
   assign column_next = column_ff + 13'd1;

   assign stat.req_row_start = req_data.row_start;
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;
   assign stat.eval_result = (phase_ff != PH_IDLE) &&
      (overrun || phase_ff == PH_LIT || (phase_ff == PH_CODE && code_count == 7'd0));
   assign stat.eval_rep = (phase_ff == PH_REP) && !overrun;
   assign stat.rep_last = (column_ff >= eff_width) || (rep_left_ff <= 7'd2) ||
      (column_next >= eff_width);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CFG_W'(1);
         height_ff <= CFG_W'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_wdata;
         end else if (csr_index == CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_ff <= req_data;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      run_in = run_ff;
      rep_left_in = rep_left_ff;
      bytes_in = bytes_ff;
      budget_in = budget_ff;
      addr_in = addr_ff;
      column_in = column_ff;
      load = 1'b0;
      rsp_data_in = '0;
      rsp_data_in.write_address = addr_ff;
      rsp_data_in.last = 1'b1;

      if (cmd.row) begin
         phase_in = PH_IDLE;
         run_in = 7'd0;
         if (13'(item_ff.row_index) < height_ff) begin
            budget_in = item_ff.row_length;
            bytes_in = 16'd0;
            column_in = 13'd0;
            addr_in = {row_product, 2'b00} + 26'(item_ff.channel);
            phase_in = PH_CODE;
         end
      end else if (cmd.eval && phase_ff != PH_IDLE) begin
         if (overrun) begin
            load = 1'b1;
            rsp_data_in.status = ST_OVERRUN;
            phase_in = PH_IDLE;
            run_in = 7'd0;
         end else begin
            bytes_in = bytes_ff + 16'd1;
            case (phase_ff)
               PH_CODE: begin
                  if (code_count == 7'd0) begin
                     load = 1'b1;
                     rsp_data_in.row_done = 1'b1;
                     phase_in = PH_IDLE;
                  end else begin
                     run_in = code_count;
                     phase_in = ((item_ff.data_byte & LITERAL_FLAG) != 8'd0) ?
                        PH_LIT : PH_REP;
                  end
               end
               PH_LIT: begin
                  load = 1'b1;
                  if (column_ff >= eff_width) begin
                     rsp_data_in.status = ST_COLUMN;
                     phase_in = PH_IDLE;
                     run_in = 7'd0;
                  end else begin
                     rsp_data_in.pixel_first = item_ff.data_byte;
                     rsp_data_in.pixel_count = 2'd1;
                     column_in = column_next;
                     addr_in = addr_ff + 26'd4;
                     run_in = run_ff - 7'd1;
                     if (run_ff == 7'd1) begin
                        phase_in = PH_CODE;
                     end
                  end
               end
               PH_REP: begin
                  rep_left_in = run_ff;
                  run_in = 7'd0;
                  phase_in = PH_CODE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end else if (cmd.rep) begin
         load = 1'b1;
         rsp_data_in.last = stat.rep_last;
         if (column_ff >= eff_width) begin
            rsp_data_in.status = ST_COLUMN;
            phase_in = PH_IDLE;
            run_in = 7'd0;
         end else begin
            rsp_data_in.pixel_first = item_ff.data_byte;
            if (rep_left_ff == 7'd1) begin
               rsp_data_in.pixel_count = 2'd1;
               column_in = column_next;
               addr_in = addr_ff + 26'd4;
               rep_left_in = 7'd0;
            end else if (column_next >= eff_width) begin
               rsp_data_in.pixel_count = 2'd1;
               rsp_data_in.status = ST_COLUMN;
               column_in = column_next;
               addr_in = addr_ff + 26'd4;
               phase_in = PH_IDLE;
               run_in = 7'd0;
            end else begin
               rsp_data_in.pixel_second = item_ff.data_byte;
               rsp_data_in.pixel_count = 2'd2;
               column_in = column_ff + 13'd2;
               addr_in = addr_ff + 26'd8;
               rep_left_in = rep_left_ff - 7'd2;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         run_ff <= 7'd0;
         rep_left_ff <= 7'd0;
         bytes_ff <= 16'd0;
         budget_ff <= 16'd0;
         addr_ff <= 26'd0;
         column_ff <= 13'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         run_ff <= run_in;
         rep_left_ff <= rep_left_in;
         bytes_ff <= bytes_in;
         budget_ff <= budget_in;
         addr_ff <= addr_in;
         column_ff <= column_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// ----- sv/rgb_image_rle_row_decoder_top.sv -----
// Top level of the RGB image RLE row decoder: controller plus datapath.
// Depends on rgbrle_pkg, rgbrle_ctrl and rgbrle_dp.
//
//   Channel   Ports                              Direction  Moves
//   request   req_valid, req_ready, req_data     in         one compressed byte item
//   response  rsp_valid, rsp_ready, rsp_data     out        one result item, 0 to 2 pixels
//   config    csr_we, csr_index, csr_wdata       in         register write, no read-back
//
// An item is taken in the wait state and evaluated in the evaluate state; no new byte is
// taken until the last one is through. A row_start byte first passes the row state, which
// loads the row address from the multiplier. A repeat byte of count n then issues up to
// ceil(n/2) results, one a cycle while the result register is free. While a result item
// waits, further bytes are still taken; the sequencer holds only when it has a result
// to load and the result register is full. Reset is synchronous and clears all row state.
`timescale 1ns / 1ps

module rgb_image_rle_row_decoder_top
   import rgbrle_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   rgbrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rgbrle_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

// ----- sv/rgbrle_checker.sv -----
// Port-level checker for the RGB image RLE row decoder, bound to the top.
// Depends on rgbrle_pkg and rgb_image_rle_row_decoder_top.
`timescale 1ns / 1ps

module rgbrle_checker
   import rgbrle_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result item changed.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel_count != 2'd3 && rsp_data.status != 2'd3)
      else $error("Pixel count or status out of range.");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last)
      else $error("Error result is not the final one of its item.");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.row_done |->
         rsp_data.last && rsp_data.pixel_count == 2'd0 && rsp_data.status == ST_OK)
      else $error("End-of-row result carries pixels or an error.");

   a_overrun_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OVERRUN |-> rsp_data.pixel_count == 2'd0)
      else $error("Budget overrun result carries pixels.");

endmodule

bind rgb_image_rle_row_decoder_top rgbrle_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- test/rgb_image_rle_row_decoder_top_test.sv -----
// Self-checking testbench for rgb_image_rle_row_decoder_top: random and directed
// compressed row bytes, a cycle-free decoder predictor and an in-order result check.
// Depends on rgbrle_pkg and the decoder top level.
`timescale 1ns / 1ps

module rgb_image_rle_row_decoder_top_test;
   import rgbrle_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 24;

   logic             clock;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [0:0]       csr_index = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;

   req_type pending_bytes[$];
   rsp_type expected_writes[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int fail_count = 0;
   int stall_cycles = 0;
   int items_made = 0;

   logic [CFG_W-1:0] cfg_width = 13'd1;
   logic [CFG_W-1:0] cfg_height = 13'd1;
   phase_type        cur_phase = PH_IDLE;
   logic [6:0]       run_left = '0;
   logic [15:0]      bytes_taken = '0;
   logic [15:0]      budget = '0;
   logic [25:0]      next_addr = '0;
   int               col = 0;

   rgb_image_rle_row_decoder_top uut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic void emit_pixels(input logic [7:0] value, input int count);
      int n;
      int got;
      int i;
      int w;
      logic [1:0] st;
      rsp_type r;
      w = eff_width();
      n = count;
      while (n > 0) begin
         got = 0;
         st = ST_OK;
         r = '0;
         r.write_address = next_addr;
         for (i = 0; i < 2; i++) begin
            if (n > 0 && st == ST_OK) begin
               if (col >= w) begin
                  st = ST_COLUMN;
               end else begin
                  col++;
                  next_addr = next_addr + 26'd4;
                  got++;
                  n--;
               end
            end
         end
         if (got > 0) r.pixel_first = value;
         if (got > 1) r.pixel_second = value;
         r.pixel_count = got[1:0];
         r.status = st;
         if (st != ST_OK) begin
            cur_phase = PH_IDLE;
            run_left = '0;
            n = 0;
         end
         r.last = (n == 0);
         expected_writes.push_back(r);
      end
   endfunction

   function automatic void decode_byte(input req_type it);
      logic [7:0] b;
      logic [6:0] cnt;
      longint a;
      rsp_type r;
      b = it.data_byte;
      r = '0;
      if (it.row_start) begin
         cur_phase = PH_IDLE;
         run_left = '0;
         if ({1'b0, it.row_index} >= cfg_height) return;
         budget = it.row_length;
         bytes_taken = '0;
         col = 0;
         a = longint'(it.row_index) * eff_width() * 4 + longint'(it.channel);
         next_addr = a[25:0];
         cur_phase = PH_CODE;
      end
      if (cur_phase == PH_IDLE) return;
      if (bytes_taken >= budget) begin
         r.write_address = next_addr;
         r.status = ST_OVERRUN;
         r.last = 1'b1;
         expected_writes.push_back(r);
         cur_phase = PH_IDLE;
         run_left = '0;
         return;
      end
      bytes_taken++;
      case (cur_phase)
         PH_CODE: begin
            cnt = b[6:0] & COUNT_MASK;
            if (cnt == 0) begin
               r.write_address = next_addr;
               r.row_done = 1'b1;
               r.status = ST_OK;
               r.last = 1'b1;
               expected_writes.push_back(r);
               cur_phase = PH_IDLE;
            end else begin
               run_left = cnt;
               cur_phase = ((b & LITERAL_FLAG) != 0) ? PH_LIT : PH_REP;
            end
         end
         PH_LIT: begin
            emit_pixels(b, 1);
            if (cur_phase == PH_LIT) begin
               run_left = run_left - 7'd1;
               if (run_left == 0) cur_phase = PH_CODE;
            end
         end
         default: begin
            cnt = run_left;
            run_left = '0;
            cur_phase = PH_CODE;
            emit_pixels(b, int'(cnt));
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_data);
         if (!req_valid || req_ready) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_bytes.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: px %h/%h cnt %0d addr %h done %b st %0d last %b",
                           rsp_data.pixel_first, rsp_data.pixel_second, rsp_data.pixel_count,
                           rsp_data.write_address, rsp_data.row_done, rsp_data.status,
                           rsp_data.last);
            end else begin
               want = expected_writes.pop_front();
               if (rsp_data.pixel_first !== want.pixel_first ||
                   rsp_data.pixel_second !== want.pixel_second ||
                   rsp_data.pixel_count !== want.pixel_count ||
                   rsp_data.write_address !== want.write_address ||
                   rsp_data.row_done !== want.row_done ||
                   rsp_data.status !== want.status ||
                   rsp_data.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch got:  px %h/%h cnt %0d addr %h done %b st %0d last %b",
                              rsp_data.pixel_first, rsp_data.pixel_second,
                              rsp_data.pixel_count, rsp_data.write_address,
                              rsp_data.row_done, rsp_data.status, rsp_data.last);
                     $display("mismatch want: px %h/%h cnt %0d addr %h done %b st %0d last %b",
                              want.pixel_first, want.pixel_second, want.pixel_count,
                              want.write_address, want.row_done, want.status, want.last);
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (pending_bytes.size() == 0 && !req_valid && expected_writes.size() == 0))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic write_register(input logic [0:0] idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_start(input logic [7:0] b, input logic [11:0] row,
                             input logic [1:0] ch, input logic [15:0] len);
      req_type it;
      it.data_byte = b;
      it.row_start = 1'b1;
      it.row_index = row;
      it.channel = ch;
      it.row_length = len;
      pending_bytes.push_back(it);
   endtask

   task automatic push_cont(input logic [7:0] b);
      req_type it;
      it.data_byte = b;
      it.row_start = 1'b0;
      it.row_index = 12'($urandom_range(4095));
      it.channel = 2'($urandom_range(3));
      it.row_length = 16'($urandom_range(65535));
      pending_bytes.push_back(it);
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_random_row(input logic [CFG_W-1:0] h);
      logic [7:0] body[$];
      logic [11:0] row;
      logic [1:0] ch;
      logic [15:0] len;
      int runs;
      int cnt;
      int nbytes;
      int pick;
      int i;
      int j;
      body = {};
      if (h == 0 || h > 4096) row = 12'($urandom_range(4095));
      else if ($urandom_range(9) == 0) row = (h > 4095) ? 12'd4095 : h[11:0];
      else row = 12'($urandom_range(int'(h) - 1));
      ch = 2'($urandom_range(3));
      runs = $urandom_range(1, 4);
      for (i = 0; i < runs; i++) begin
         if ($urandom_range(1) == 1) begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            body.push_back(LITERAL_FLAG | cnt[7:0]);
            for (j = 0; j < cnt; j++) body.push_back(8'($urandom_range(255)));
         end else begin
            cnt = ($urandom_range(4) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 12);
            body.push_back(cnt[7:0]);
            body.push_back(8'($urandom_range(255)));
         end
      end
      body.push_back($urandom_range(1) ? LITERAL_FLAG : 8'h00);
      nbytes = body.size();
      len = 16'(body.size());
      pick = $urandom_range(99);
      if (pick >= 72 && pick < 82) begin
         len = 16'($urandom_range(body.size() - 1));
      end else if (pick >= 82 && pick < 90) begin
         nbytes = $urandom_range(1, body.size() - 1);
      end else if (pick >= 90) begin
         len = 16'($urandom_range(65535));
      end
      for (j = 0; j < nbytes; j++) begin
         if (j == 0) push_start(body[0], row, ch, len);
         else push_cont(body[j]);
      end
      items_made += nbytes;
      if ($urandom_range(9) == 0) begin
         cnt = $urandom_range(1, 3);
         for (j = 0; j < cnt; j++) push_cont(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                   input int send_pct, input int recv_pct, input int target);
      int j;
      int cnt;
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      items_made = 0;
      while (items_made < target) begin
         if ($urandom_range(19) == 0) begin
            push_start(8'($urandom_range(255)), 12'($urandom_range(4095)),
                       2'($urandom_range(3)), 16'($urandom_range(65535)));
            cnt = $urandom_range(1, 5);
            for (j = 0; j < cnt; j++) push_cont(8'($urandom_range(255)));
            items_made += cnt + 1;
         end else begin
            add_random_row(h);
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_register(CSR_IMAGE_WIDTH, 13'd8);
      write_register(CSR_IMAGE_HEIGHT, 13'd4);
      // Stray byte with no row active, then plain literal and repeat rows.
      push_cont(8'h55);
      push_start(8'h83, 12'd0, 2'd0, 16'd5);
      push_cont(8'h00);
      push_cont(8'hff);
      push_cont(8'h5a);
      push_cont(8'h00);
      push_start(8'h05, 12'd1, 2'd3, 16'd3);
      push_cont(8'ha5);
      push_cont(8'h80);
      // Row index out of range, then byte budget overruns.
      push_start(8'h01, 12'd4, 2'd2, 16'd9);
      push_cont(8'h33);
      push_start(8'h02, 12'd2, 2'd1, 16'd1);
      push_cont(8'h11);
      push_start(8'h00, 12'd3, 2'd0, 16'd0);
      // Column overflow in a repeat run and in a literal run.
      push_start(8'h0a, 12'd3, 2'd2, 16'd3);
      push_cont(8'h77);
      push_start(8'h07, 12'd2, 2'd3, 16'd10);
      push_cont(8'hc3);
      push_cont(8'h82);
      push_cont(8'h01);
      push_cont(8'h02);
      // A row abandoned by the start of the next one.
      push_start(8'h84, 12'd0, 2'd1, 16'd8);
      push_cont(8'h9e);
      push_start(8'h7f, 12'd1, 2'd2, 16'd2);
      push_cont(8'he1);
      wait_drained();

      run_random_phase(13'd4096, 13'd4096, 0, 0, 50);
      run_random_phase(13'd1, 13'd1, 63, 0, 30);
      run_random_phase(13'd20, 13'd64, 0, 63, 50);
      run_random_phase(13'd8191, 13'd2, 32, 32, 40);
      run_random_phase(13'd0, 13'd8191, 0, 0, 20);
      run_random_phase(13'd37, 13'd5, 63, 0, 50);
      run_random_phase(13'd13, 13'd0, 0, 63, 10);
      run_random_phase(13'd100, 13'd4096, 32, 32, 50);

      if (fail_count == 0 && expected_writes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
